>>> rtl/core/ugli_pkg.sv
package ugli_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // front/back queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // register word index (paddr[3:2])
    localparam logic [1:0] REG_X_MIN      = 2'd0;
    localparam logic [1:0] REG_INV_STEP   = 2'd1;
    localparam logic [1:0] REG_TABLE_SIZE = 2'd2;

    typedef enum logic {
        OP_LOAD,
        OP_QUERY
    } op_t;

    typedef struct packed {
        logic               req_type;
        logic [9:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] query_x;
        logic               last_query;
    } in_req_t;

    typedef struct packed {
        logic signed [31:0] interp_value;
        logic               in_range;
        logic               last_out;
    } out_res_t;

    typedef struct packed {
        logic signed [31:0] x_min;
        logic [31:0]        inv_step;
        logic [10:0]        table_size;
    } cfg_t;

    // hit: load slot exists, or query lies inside the grid
    typedef struct packed {
        op_t               op;
        logic              hit;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       data;
        logic              last;
    } q_entry_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } q_stat_t;

endpackage

>>> rtl/core/ugli_front.sv
module ugli_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ugli_pkg::in_req_t req,
    input  ugli_pkg::cfg_t    cfg,
    input  ugli_pkg::q_stat_t qstat,
    output logic              push,
    output ugli_pkg::q_entry_t push_entry
);

    localparam int CRED_W = ugli_pkg::QCNT_W + 1;

    logic        accept;
    logic        s1_valid_reg;
    logic        s2_valid_reg;

    logic        s1_query_reg;
    logic [9:0]  s1_index_reg;
    logic [31:0] s1_value_reg;
    logic [31:0] s1_diff_reg;
    logic        s1_below_reg;
    logic        s1_last_reg;

    logic        s2_query_reg;
    logic [9:0]  s2_index_reg;
    logic [31:0] s2_value_reg;
    logic [63:0] s2_pos_reg;
    logic        s2_below_reg;
    logic        s2_last_reg;

    logic signed [32:0] diff_wide;
    logic [CRED_W-1:0]  in_flight;
    logic [32:0]        idx_p1;
    logic [32:0]        eff_size;

    // credit check: queue plus everything still in the front pipe
    assign in_flight = CRED_W'(qstat.count) + CRED_W'(s1_valid_reg) + CRED_W'(s2_valid_reg);
    assign busy      = in_flight >= CRED_W'(ugli_pkg::QDEPTH);
    assign accept    = start && !busy;

    assign diff_wide = $signed({req.query_x[31], req.query_x})
                     - $signed({cfg.x_min[31], cfg.x_min});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_query_reg <= (req.req_type == ugli_pkg::REQ_QUERY);
            s1_index_reg <= req.entry_index;
            s1_value_reg <= req.entry_value;
            // below the grid is out of range unless inv_step is zero (then pos is 0)
            s1_diff_reg  <= diff_wide[32] ? 32'd0 : diff_wide[31:0];
            s1_below_reg <= diff_wide[32] && (cfg.inv_step != 32'd0);
            s1_last_reg  <= req.last_query;
        end
        if (s1_valid_reg)
        begin
            s2_query_reg <= s1_query_reg;
            s2_index_reg <= s1_index_reg;
            s2_value_reg <= s1_value_reg;
            s2_pos_reg   <= s1_diff_reg * cfg.inv_step;
            s2_below_reg <= s1_below_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    assign idx_p1   = {1'b0, s2_pos_reg[63:32]} + 33'd1;
    assign eff_size = (33'(cfg.table_size) < 33'(ugli_pkg::TABLE_DEPTH))
                    ? 33'(cfg.table_size) : 33'(ugli_pkg::TABLE_DEPTH);

    assign push = s2_valid_reg;

    always_comb
    begin
        push_entry.last = s2_last_reg;
        if (s2_query_reg)
        begin
            push_entry.op   = ugli_pkg::OP_QUERY;
            push_entry.hit  = !s2_below_reg && (idx_p1 < eff_size);
            push_entry.addr = s2_pos_reg[32 +: ugli_pkg::ADDR_W];
            push_entry.data = {16'd0, s2_pos_reg[31:16]};
        end
        else
        begin
            push_entry.op   = ugli_pkg::OP_LOAD;
            push_entry.hit  = 32'(s2_index_reg) < 32'(ugli_pkg::TABLE_DEPTH);
            push_entry.addr = ugli_pkg::ADDR_W'(s2_index_reg);
            push_entry.data = s2_value_reg;
        end
    end

endmodule

>>> rtl/core/ugli_queue.sv
module ugli_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ugli_pkg::q_entry_t  push_entry,
    output logic                pop,
    output ugli_pkg::q_entry_t  pop_entry,
    output ugli_pkg::q_stat_t   qstat
);

    ugli_pkg::q_entry_t              slot_reg [ugli_pkg::QDEPTH];
    logic [ugli_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [ugli_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [ugli_pkg::QCNT_W-1:0]     count_reg;
    logic [ugli_pkg::QCNT_W-1:0]     count_next;

    // back end never stalls: drain whenever something is queued
    assign pop         = count_reg != '0;
    assign pop_entry   = slot_reg[rd_ptr_reg];
    assign qstat.count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (!push && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && count_reg == ugli_pkg::QCNT_W'(ugli_pkg::QDEPTH)))
        else $error("request queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ugli_pkg::QCNT_W'(ugli_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("queue count did not drop on pop");

endmodule

>>> rtl/core/ugli_back.sv
module ugli_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop,
    input  ugli_pkg::q_entry_t pop_entry,
    output logic               done,
    output ugli_pkg::out_res_t res
);

    logic [31:0] sample_mem [ugli_pkg::TABLE_DEPTH];

    logic        b1_valid_reg;
    logic        b1_hit_reg;
    logic [15:0] b1_frac_reg;
    logic        b1_last_reg;
    logic [31:0] rd0_reg;
    logic [31:0] rd1_reg;

    logic               b2_valid_reg;
    logic               b2_hit_reg;
    logic               b2_last_reg;
    logic [31:0]        b2_y0_reg;
    logic signed [49:0] b2_prod_reg;

    logic               done_reg;
    ugli_pkg::out_res_t res_reg;

    logic               pop_query;
    logic signed [32:0] dy;
    logic signed [49:0] blend;

    assign pop_query = pop && (pop_entry.op == ugli_pkg::OP_QUERY);

    // one pop a cycle, so a write and the reads never share an edge
    always_ff @(posedge clk)
    begin
        if (pop && pop_entry.op == ugli_pkg::OP_LOAD && pop_entry.hit)
            sample_mem[pop_entry.addr] <= pop_entry.data;
        if (pop_query)
        begin
            rd0_reg <= sample_mem[pop_entry.addr];
            rd1_reg <= sample_mem[pop_entry.addr + ugli_pkg::ADDR_W'(1)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= pop_query;
            b2_valid_reg <= b1_valid_reg;
            done_reg     <= b2_valid_reg;
        end
    end

    assign dy = $signed({rd1_reg[31], rd1_reg}) - $signed({rd0_reg[31], rd0_reg});

    // arithmetic shift of the exact product gives the floor
    assign blend = b2_prod_reg >>> 16;

    always_ff @(posedge clk)
    begin
        if (pop_query)
        begin
            b1_hit_reg  <= pop_entry.hit;
            b1_frac_reg <= pop_entry.data[15:0];
            b1_last_reg <= pop_entry.last;
        end
        if (b1_valid_reg)
        begin
            b2_hit_reg  <= b1_hit_reg;
            b2_last_reg <= b1_last_reg;
            b2_y0_reg   <= rd0_reg;
            b2_prod_reg <= dy * $signed({1'b0, b1_frac_reg});
        end
        if (b2_valid_reg)
        begin
            res_reg.interp_value <= b2_hit_reg ? $signed(b2_y0_reg + blend[31:0]) : 32'sd0;
            res_reg.in_range     <= b2_hit_reg;
            res_reg.last_out     <= b2_last_reg;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

    a_query_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop_query |-> ##3 done)
        else $error("query produced no result strobe");

    a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(b1_valid_reg, 2))
        else $error("result strobe without a query");

endmodule

>>> rtl/core/uniform_grid_linear_interp_top.sv
// Linear interpolation over a uniform-grid sample table of ugli_pkg::TABLE_DEPTH
// entries. A load request writes one entry and gives no result; a query request
// gives exactly one result, strobed by done for one cycle. Requests are taken
// one per cycle (start high, busy low) and results are issued in request order,
// one per cycle at most; busy rises only when the four-entry request queue
// between the front end (subtract, 32x32 position multiply, range check) and
// the table end (dual-read table, blend multiply, add) has no free credit.
// Because the receiver cannot stall, the table end drains the queue whenever it
// holds an entry. Table entries hold no reset value: load every entry a query
// may touch first. Registers (APB, byte addresses): 0x0 x_min, 0x4 inv_step,
// 0x8 table_size; write them only while no request is in flight.
module uniform_grid_linear_interp_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  ugli_pkg::in_req_t  req,
    output logic               done,
    output ugli_pkg::out_res_t res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    ugli_pkg::cfg_t     cfg_reg;
    ugli_pkg::q_stat_t  qstat;
    ugli_pkg::q_entry_t push_entry;
    ugli_pkg::q_entry_t pop_entry;
    logic               push;
    logic               pop;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_min      <= 32'sd0;
            cfg_reg.inv_step   <= 32'd65536;
            cfg_reg.table_size <= 11'd2;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                ugli_pkg::REG_X_MIN:      cfg_reg.x_min      <= $signed(pwdata);
                ugli_pkg::REG_INV_STEP:   cfg_reg.inv_step   <= pwdata;
                ugli_pkg::REG_TABLE_SIZE: cfg_reg.table_size <= pwdata[10:0];
                default:                  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            ugli_pkg::REG_X_MIN:      prdata = cfg_reg.x_min;
            ugli_pkg::REG_INV_STEP:   prdata = cfg_reg.inv_step;
            ugli_pkg::REG_TABLE_SIZE: prdata = {21'd0, cfg_reg.table_size};
            default:                  prdata = 32'd0;
        endcase
    end

    ugli_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .cfg        (cfg_reg),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    ugli_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    ugli_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop       (pop),
        .pop_entry (pop_entry),
        .done      (done),
        .res       (res)
    );

endmodule
